/* rtl/core/obs_pkg.sv */
package obs_pkg;

    // sizing
    localparam int MAX_BOXES_DEF = 32;
    localparam int COORD_BITS    = 12;
    localparam int LIMIT_W       = 17;
    localparam int SCALE_W       = 11;
    localparam int FACE_W        = 6;
    localparam int LEFT_W        = 14;
    localparam int RIGHT_W       = 15;
    localparam int AREA_W        = 2 * COORD_BITS;
    localparam int EDGE_W        = COORD_BITS + 1;
    localparam int INTER_W       = 2 * EDGE_W;
    localparam int SCALE_FRAC    = 8;
    localparam int LIMIT_FRAC    = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COORD_SCALE   = 2'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd32768;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 11'd333;

    // saturation limits of the scaled corners
    localparam logic [LEFT_W-1:0]  LEFT_MAX  = 14'd16383;
    localparam logic [RIGHT_W-1:0] RIGHT_MAX = 15'd32767;

    typedef struct packed {
        logic                  new_image;
        logic [2:0]            source_tag;
        logic [COORD_BITS-1:0] box_x;
        logic [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-1:0] box_w;
        logic [COORD_BITS-1:0] box_h;
    } box_in_t;

    typedef struct packed {
        logic               accepted;
        logic [FACE_W-1:0]  face_index;
        logic               list_full;
        logic [2:0]         tag_out;
        logic [LEFT_W-1:0]  left_scaled;
        logic [LEFT_W-1:0]  top_scaled;
        logic [RIGHT_W-1:0] right_scaled;
        logic [RIGHT_W-1:0] bottom_scaled;
    } result_t;

    // one entry of the kept list
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } box_t;

    // status of the overlap pipeline back to the sequencer
    typedef struct packed {
        logic busy;
        logic hit;
    } ovl_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } obs_state_t;

endpackage

/* rtl/core/overlap_box_suppressor.sv */
// Greedy overlap suppression of detection boxes.
// Input channel (in_valid / in_ready / in_box): one box per transfer. The box
// is compared with every box kept so far for the current image; new_image
// empties the kept list first. Output channel (out_valid / out_ready /
// out_result): exactly one result per input box, in order, carrying the keep
// decision, the list index, the list-full flag, the tag and scaled corners.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
// the Q16 overlap limit, index 1 the Q8 corner scale; always ready. The user
// must see it written only while no box is in flight; the block does not
// enforce this. The block takes one box at a time: the next input transfer
// waits until the result of the last box is loaded. The kept list holds at
// most MAX_BOXES boxes and lives in a one-port-read RAM read one entry per
// cycle, feeding a three-stage compare pipeline. The result is registered.
// Reset empties the kept list and restores the default limit and scale.
// A stalled receiver holds the result register; the block then accepts the
// next box and works on it, and waits only when its own result is ready.
module overlap_box_suppressor #(
    parameter int MAX_BOXES = obs_pkg::MAX_BOXES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  obs_pkg::box_in_t                   in_box,
    output logic                               out_valid,
    input  logic                               out_ready,
    output obs_pkg::result_t                   out_result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [obs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [obs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import obs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    obs_state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               drop_reg, drop_next;
    logic               out_valid_reg, out_valid_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [SCALE_W-1:0] scale_reg;

    box_t       box_reg;
    logic [2:0] tag_reg;
    result_t    out_reg, res_next;

    logic        rd_issue;
    logic        ram_we;
    logic        load_out;
    box_t        kept_box;
    ovl_status_t ovl_status;

    logic [LEFT_W-1:0]       left_s, top_s;
    logic [RIGHT_W-1:0]      right_s, bottom_s;
    logic [CNT_W+FACE_W-1:0] face_ext;
    logic                    list_has_room;

    // kept list storage
    obs_ram #(
        .WIDTH ($bits(box_t)),
        .DEPTH (MAX_BOXES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (box_reg),
        .re    (rd_issue),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (kept_box)
    );

    // overlap compare pipeline
    obs_overlap u_overlap (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (rd_issue),
        .new_box  (box_reg),
        .kept_box (kept_box),
        .limit    (limit_reg),
        .status   (ovl_status)
    );

    // corner scaling
    obs_scale u_scale (
        .clk           (clk),
        .box           (box_reg),
        .scale         (scale_reg),
        .left_scaled   (left_s),
        .top_scaled    (top_s),
        .right_scaled  (right_s),
        .bottom_scaled (bottom_s)
    );

    assign list_has_room = (count_reg < CNT_W'(MAX_BOXES));
    assign face_ext      = (CNT_W + FACE_W)'(count_reg);

    // result word
    always_comb
    begin
        res_next.accepted      = !drop_reg;
        res_next.face_index    = face_ext[FACE_W-1:0];
        res_next.list_full     = !drop_reg && !list_has_room;
        res_next.tag_out       = tag_reg;
        res_next.left_scaled   = left_s;
        res_next.top_scaled    = top_s;
        res_next.right_scaled  = right_s;
        res_next.bottom_scaled = bottom_s;
    end

    // sequencer: next state and controls
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        drop_next      = drop_reg;
        in_ready       = 1'b0;
        rd_issue       = 1'b0;
        ram_we         = 1'b0;
        load_out       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                    drop_next  = 1'b0;
                    if (in_box.new_image)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                drop_next = drop_reg || ovl_status.hit;
                if (idx_reg == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_issue = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                drop_next = drop_reg || ovl_status.hit;
                if (!ovl_status.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (!drop_reg && list_has_room)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // output register valid
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            scale_reg     <= SCALE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_OVERLAP_LIMIT)
                begin
                    limit_reg <= cfg_data[LIMIT_W-1:0];
                end
                else if (cfg_index == CFG_COORD_SCALE)
                begin
                    scale_reg <= cfg_data[SCALE_W-1:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            box_reg.x <= in_box.box_x;
            box_reg.y <= in_box.box_y;
            box_reg.w <= in_box.box_w;
            box_reg.h <= in_box.box_h;
            tag_reg   <= in_box.source_tag;
        end
        if (load_out)
        begin
            out_reg <= res_next;
        end
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

/* rtl/core/obs_ram.sv */
module obs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/obs_overlap.sv */
module obs_overlap (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          issue,
    input  obs_pkg::box_t                 new_box,
    input  obs_pkg::box_t                 kept_box,
    input  logic [obs_pkg::LIMIT_W-1:0]   limit,
    output obs_pkg::ovl_status_t          status
);

    import obs_pkg::*;

    localparam int PROD_W = LIMIT_W + AREA_W;
    localparam int CMP_W  = INTER_W + LIMIT_FRAC;

    logic v0_reg, v1_reg, v2_reg;

    logic [AREA_W-1:0]  area_new_reg;
    logic [EDGE_W-1:0]  dx_reg, dy_reg, dx_next, dy_next;
    logic [AREA_W-1:0]  area_kept_reg;
    logic [INTER_W-1:0] inter_reg;
    logic [AREA_W-1:0]  big_reg, big_next;

    logic [EDGE_W-1:0]     ax2, ay2, bx2, by2, rx, ry, lx, ly;
    logic [PROD_W-1:0]     limit_prod;
    logic [CMP_W-1:0]      lhs, rhs;

    // valid bits of the stages in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // intersection extents, clamped at zero per axis
    always_comb
    begin
        ax2 = EDGE_W'(new_box.x) + EDGE_W'(new_box.w);
        ay2 = EDGE_W'(new_box.y) + EDGE_W'(new_box.h);
        bx2 = EDGE_W'(kept_box.x) + EDGE_W'(kept_box.w);
        by2 = EDGE_W'(kept_box.y) + EDGE_W'(kept_box.h);
        lx  = (new_box.x > kept_box.x) ? EDGE_W'(new_box.x) : EDGE_W'(kept_box.x);
        ly  = (new_box.y > kept_box.y) ? EDGE_W'(new_box.y) : EDGE_W'(kept_box.y);
        rx  = (ax2 < bx2) ? ax2 : bx2;
        ry  = (ay2 < by2) ? ay2 : by2;
        dx_next = (rx > lx) ? (rx - lx) : '0;
        dy_next = (ry > ly) ? (ry - ly) : '0;
        big_next = (area_new_reg > area_kept_reg) ? area_new_reg : area_kept_reg;
    end

    // stage 1: extents and kept area, stage 2: intersection and larger area
    always_ff @(posedge clk)
    begin
        area_new_reg  <= AREA_W'(new_box.w) * AREA_W'(new_box.h);
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        area_kept_reg <= AREA_W'(kept_box.w) * AREA_W'(kept_box.h);
        inter_reg     <= INTER_W'(dx_reg) * INTER_W'(dy_reg);
        big_reg       <= big_next;
    end

    // stage 3: inter * 2^16 against limit * larger area
    always_comb
    begin
        limit_prod = PROD_W'(limit) * PROD_W'(big_reg);
        lhs        = {inter_reg, {LIMIT_FRAC{1'b0}}};
        rhs        = CMP_W'(limit_prod);
        status.hit  = v2_reg && (lhs > rhs);
        status.busy = v0_reg || v1_reg || v2_reg;
    end

endmodule

/* rtl/core/obs_scale.sv */
module obs_scale (
    input  logic                              clk,
    input  obs_pkg::box_t                     box,
    input  logic [obs_pkg::SCALE_W-1:0]       scale,
    output logic [obs_pkg::LEFT_W-1:0]        left_scaled,
    output logic [obs_pkg::LEFT_W-1:0]        top_scaled,
    output logic [obs_pkg::RIGHT_W-1:0]       right_scaled,
    output logic [obs_pkg::RIGHT_W-1:0]       bottom_scaled
);

    import obs_pkg::*;

    localparam int PL_W = COORD_BITS + SCALE_W;
    localparam int PR_W = EDGE_W + SCALE_W;
    localparam int QL_W = PL_W - SCALE_FRAC;
    localparam int QR_W = PR_W - SCALE_FRAC;

    logic [PL_W-1:0] px_reg, py_reg;
    logic [PR_W-1:0] pr_reg, pb_reg;
    logic [QL_W-1:0] qx, qy;
    logic [QR_W-1:0] qr, qb;

    // corner products, one multiplier per corner
    always_ff @(posedge clk)
    begin
        px_reg <= PL_W'(box.x) * PL_W'(scale);
        py_reg <= PL_W'(box.y) * PL_W'(scale);
        pr_reg <= (PR_W'(box.x) + PR_W'(box.w)) * PR_W'(scale);
        pb_reg <= (PR_W'(box.y) + PR_W'(box.h)) * PR_W'(scale);
    end

    // drop the fraction and saturate
    always_comb
    begin
        qx = px_reg[PL_W-1:SCALE_FRAC];
        qy = py_reg[PL_W-1:SCALE_FRAC];
        qr = pr_reg[PR_W-1:SCALE_FRAC];
        qb = pb_reg[PR_W-1:SCALE_FRAC];
        left_scaled   = (qx > QL_W'(LEFT_MAX))  ? LEFT_MAX  : qx[LEFT_W-1:0];
        top_scaled    = (qy > QL_W'(LEFT_MAX))  ? LEFT_MAX  : qy[LEFT_W-1:0];
        right_scaled  = (qr > QR_W'(RIGHT_MAX)) ? RIGHT_MAX : qr[RIGHT_W-1:0];
        bottom_scaled = (qb > QR_W'(RIGHT_MAX)) ? RIGHT_MAX : qb[RIGHT_W-1:0];
    end

endmodule
